[hdl/lzbf_pkg.sv]
// ---------------------------------------------------------------------------
// lzbf_pkg: shared types and constants of the bit-flag LZ77 decompressor
// Holds the word layouts, window and header sizes, decode step codes and
// status codes used by the front, the back and the output interface.
// ---------------------------------------------------------------------------
package lzbf_pkg;

    localparam int WIN_BYTES  = 8192;
    localparam int WIN_AW     = $clog2(WIN_BYTES);
    localparam int LANE_BYTES = 8;
    localparam int SIZE_BITS  = 22;
    localparam int HDR_LEN    = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Decode step codes of the token parser.
    localparam logic [4:0] DS_TOKEN = 5'd0;
    localparam logic [4:0] DS_KIND  = 5'd1;
    localparam logic [4:0] DS_LIT   = 5'd2;
    localparam logic [4:0] DS_LOFS  = 5'd3;
    localparam logic [4:0] DS_SOFS  = 5'd4;
    localparam logic [4:0] DS_LENB  = 5'd5;
    localparam logic [4:0] DS_L1    = 5'd6;
    localparam logic [4:0] DS_L2    = 5'd7;
    localparam logic [4:0] DS_L3    = 5'd8;
    localparam logic [4:0] DS_L4    = 5'd9;
    localparam logic [4:0] DS_L5    = 5'd10;
    localparam logic [4:0] DS_L6    = 5'd11;
    localparam logic [4:0] DS_L7    = 5'd12;
    localparam logic [4:0] DS_L8    = 5'd13;
    localparam logic [4:0] DS_C0    = 5'd14;
    localparam logic [4:0] DS_C1    = 5'd15;
    localparam logic [4:0] DS_C2    = 5'd16;
    localparam logic [4:0] DS_C3    = 5'd17;
    localparam logic [4:0] DS_C4    = 5'd18;
    localparam logic [4:0] DS_C5    = 5'd19;
    localparam logic [4:0] DS_C6    = 5'd20;
    localparam logic [4:0] DS_C7    = 5'd21;
    localparam logic [4:0] DS_C8    = 5'd22;
    localparam logic [4:0] DS_C9    = 5'd23;
    localparam logic [4:0] DS_S1    = 5'd24;
    localparam logic [4:0] DS_S2    = 5'd25;
    localparam logic [4:0] DS_S3    = 5'd26;
    localparam logic [4:0] DS_S4    = 5'd27;
    localparam logic [4:0] DS_S5    = 5'd28;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SHORT = 2'd1;
    localparam logic [1:0] STAT_DIST  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [8*LANE_BYTES-1:0] out_bytes;
        logic [3:0]              byte_count;
        logic                    run_end;
        logic                    stream_done;
        logic [1:0]              status;
    } out_word_t;

endpackage

[hdl/lzbf_if.sv]
// ---------------------------------------------------------------------------
// lzbf_if: stream channels of the decompressor
// One channel carries compressed input words, the other carries groups of
// decoded bytes. Both use a valid/ready handshake.
// ---------------------------------------------------------------------------
interface lzbf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface lzbf_out_if;
    import lzbf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [8*LANE_BYTES-1:0] out_bytes;
    logic [3:0]              byte_count;
    logic                    run_end;
    logic                    stream_done;
    logic [1:0]              status;

    modport source (output valid, output out_bytes, output byte_count, output run_end,
                    output stream_done, output status, input ready);
    modport sink   (input valid, input out_bytes, input byte_count, input run_end,
                    input stream_done, input status, output ready);
endinterface

[hdl/lzbf_ram.sv]
// ---------------------------------------------------------------------------
// lzbf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lzbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[hdl/lzbf_front.sv]
// ---------------------------------------------------------------------------
// lzbf_front: input queue of the decompressor
// Takes compressed words from the input channel into a short queue so the
// input side keeps flowing while the back end decodes or copies.
// ---------------------------------------------------------------------------
module lzbf_front (
    input  logic              clk,
    input  logic              rst_n,
    lzbf_in_if.sink           in_ch,
    output lzbf_pkg::in_word_t q_word,
    output logic              q_valid,
    input  logic              q_ready
);
    import lzbf_pkg::*;

    in_word_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic                  push;
    logic                  pop;

    assign in_ch.ready = (count_reg < (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (count_reg != '0);
    assign pop         = q_valid && q_ready;
    assign q_word      = slot_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{data_byte: in_ch.data_byte, final_byte: in_ch.final_byte};
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
            end
        end
    end
endmodule

[hdl/lzbf_back.sv]
// ---------------------------------------------------------------------------
// lzbf_back: decoding engine of the decompressor
// Parses the header and flag words, walks tokens one flag bit per cycle, runs
// match copies through the history RAM and packs decoded bytes into words.
// ---------------------------------------------------------------------------
module lzbf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  lzbf_pkg::in_word_t q_word,
    input  logic               q_valid,
    output logic               q_ready,
    lzbf_out_if.source         out_ch
);
    import lzbf_pkg::*;

    localparam logic [2:0] FS_IDLE  = 3'd0;
    localparam logic [2:0] FS_RUN   = 3'd1;
    localparam logic [2:0] FS_CSET  = 3'd2;
    localparam logic [2:0] FS_CRD   = 3'd3;
    localparam logic [2:0] FS_CWR   = 3'd4;
    localparam logic [2:0] FS_FLUSH = 3'd5;

    logic [2:0]              state_reg,    state_next;
    logic [SIZE_BITS-1:0]    produced_reg, produced_next;
    logic [SIZE_BITS-1:0]    target_reg,   target_next;
    logic [3:0]              hdr_reg,      hdr_next;
    logic [16:0]             flag_reg,     flag_next;
    logic [7:0]              wlow_reg,     wlow_next;
    logic                    whalf_reg,    whalf_next;
    logic [4:0]              step_reg,     step_next;
    logic [13:0]             dist_reg,     dist_next;
    logic [11:0]             shift_reg,    shift_next;
    logic [8:0]              mlen_reg,     mlen_next;
    logic                    fin_reg,      fin_next;
    logic [1:0]              fault_reg,    fault_next;
    logic                    last_reg,     last_next;
    logic [8:0]              clen_reg,     clen_next;
    logic [13:0]             cdist_reg,    cdist_next;
    logic                    mdone_reg,    mdone_next;
    logic [1:0]              mstat_reg,    mstat_next;
    logic [8*LANE_BYTES-1:0] lane_reg,     lane_next;
    logic [3:0]              fill_reg,     fill_next;
    logic                    out_v_reg,    out_v_next;
    out_word_t               out_w_reg,    out_w_next;

    logic               out_free;
    logic               ram_we;
    logic [WIN_AW-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic [WIN_AW-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;
    logic [7:0]         b;
    logic               bit_v;
    logic [13:0]        d_sum;
    logic [SIZE_BITS-1:0] room;
    logic [SIZE_BITS-1:0] diff;
    logic               need_byte;
    logic [1:0]         fin_stat;

    lzbf_ram #(.WIDTH(8), .DEPTH(WIN_BYTES)) u_hist (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign out_free = !out_v_reg || out_ch.ready;
    assign q_ready  = (state_reg == FS_IDLE);
    assign b        = q_word.data_byte;
    assign bit_v    = flag_reg[0];
    assign d_sum    = dist_reg + 14'(shift_reg);
    assign room     = target_reg - produced_reg;
    assign diff     = produced_reg - SIZE_BITS'(cdist_reg);
    assign ram_raddr = diff[WIN_AW-1:0];
    assign need_byte = (step_reg == DS_LIT) || (step_reg == DS_LOFS)
                    || (step_reg == DS_SOFS) || (step_reg == DS_LENB);

    // Status of the closing word of an input byte.
    always_comb
    begin
        fin_stat = fault_reg;
        if (last_reg && fault_reg == STAT_OK
            && (hdr_reg < 4'(HDR_LEN) || flag_reg == 17'd1 || !fin_reg))
        begin
            fin_stat = STAT_SHORT;
        end
    end

    // Next-state logic of the decoder.
    always_comb
    begin
        state_next    = state_reg;
        produced_next = produced_reg;
        target_next   = target_reg;
        hdr_next      = hdr_reg;
        flag_next     = flag_reg;
        wlow_next     = wlow_reg;
        whalf_next    = whalf_reg;
        step_next     = step_reg;
        dist_next     = dist_reg;
        shift_next    = shift_reg;
        mlen_next     = mlen_reg;
        fin_next      = fin_reg;
        fault_next    = fault_reg;
        last_next     = last_reg;
        clen_next     = clen_reg;
        cdist_next    = cdist_reg;
        mdone_next    = mdone_reg;
        mstat_next    = mstat_reg;
        lane_next     = lane_reg;
        fill_next     = fill_reg;
        out_v_next    = out_v_reg && !out_ch.ready;
        out_w_next    = out_w_reg;
        ram_we        = 1'b0;
        ram_waddr     = produced_reg[WIN_AW-1:0];
        ram_wdata     = b;

        unique case (state_reg)
            FS_IDLE:
            begin
                if (q_valid)
                begin
                    last_next  = q_word.final_byte;
                    state_next = FS_RUN;
                    if (hdr_reg < 4'(HDR_LEN))
                    begin
                        // Header bytes: pick up the output size.
                        if (hdr_reg == 4'd10)
                        begin
                            target_next[21:16] = b[7:2];
                        end
                        else if (hdr_reg == 4'd11)
                        begin
                            target_next[7:0] = b;
                        end
                        else if (hdr_reg == 4'd12)
                        begin
                            target_next[15:8] = b;
                        end
                        hdr_next = hdr_reg + 4'd1;
                        if (hdr_reg == 4'(HDR_LEN - 1))
                        begin
                            flag_next = flag_reg >> 1;
                        end
                        else
                        begin
                            state_next = FS_FLUSH;
                        end
                    end
                    else if (flag_reg == 17'd1)
                    begin
                        // Flag word fetch, low byte first.
                        if (!whalf_reg)
                        begin
                            wlow_next  = b;
                            whalf_next = 1'b1;
                        end
                        else
                        begin
                            flag_next  = {1'b1, b, wlow_reg};
                            whalf_next = 1'b0;
                        end
                    end
                    else if (!fin_reg && fault_reg == STAT_OK && need_byte)
                    begin
                        unique case (step_reg)
                            DS_LIT:
                            begin
                                ram_we        = 1'b1;
                                lane_next[8*fill_reg[2:0] +: 8] = b;
                                fill_next     = fill_reg + 4'd1;
                                produced_next = produced_reg + SIZE_BITS'(1);
                                step_next     = DS_TOKEN;
                            end
                            DS_LOFS:
                            begin
                                dist_next  = 14'(9'h100 - {1'b0, b});
                                shift_next = '0;
                                step_next  = DS_L1;
                            end
                            DS_SOFS:
                            begin
                                dist_next  = 14'(9'h100 - {1'b0, b});
                                shift_next = '0;
                                step_next  = DS_S1;
                            end
                            default:
                            begin
                                mlen_next  = 9'(b) + 9'd17;
                                clen_next  = 9'(b) + 9'd17;
                                state_next = FS_CSET;
                            end
                        endcase
                    end
                end
            end

            FS_RUN:
            begin
                if (fin_reg || fault_reg != STAT_OK)
                begin
                    state_next = FS_FLUSH;
                end
                else if (step_reg == DS_TOKEN && produced_reg >= target_reg)
                begin
                    fin_next   = 1'b1;
                    state_next = FS_FLUSH;
                end
                else if (need_byte || flag_reg <= 17'd1)
                begin
                    state_next = FS_FLUSH;
                end
                else
                begin
                    // One flag bit per cycle.
                    flag_next = flag_reg >> 1;
                    unique case (step_reg)
                        DS_TOKEN: step_next = bit_v ? DS_LIT : DS_KIND;
                        DS_KIND:  step_next = bit_v ? DS_LOFS : DS_SOFS;
                        DS_L1:
                        begin
                            if (!bit_v) shift_next = shift_reg + 12'h100;
                            step_next = DS_L2;
                        end
                        DS_L2:
                        begin
                            if (!bit_v)
                            begin
                                dist_next = dist_reg + 14'h200;
                                step_next = DS_L3;
                            end
                            else step_next = DS_C0;
                        end
                        DS_L3, DS_L5:
                        begin
                            if (!bit_v)
                            begin
                                shift_next = shift_reg << 1;
                                step_next  = (step_reg == DS_L3) ? DS_L4 : DS_L6;
                            end
                            else step_next = DS_C0;
                        end
                        DS_L4:
                        begin
                            if (!bit_v) shift_next = shift_reg + 12'h100;
                            dist_next = dist_reg + 14'h200;
                            step_next = DS_L5;
                        end
                        DS_L6:
                        begin
                            if (!bit_v) shift_next = shift_reg + 12'h100;
                            dist_next = dist_reg + 14'h400;
                            step_next = DS_L7;
                        end
                        DS_L7:
                        begin
                            if (!bit_v)
                            begin
                                dist_next  = dist_reg + 14'h800;
                                shift_next = shift_reg << 1;
                                step_next  = DS_L8;
                            end
                            else step_next = DS_C0;
                        end
                        DS_L8:
                        begin
                            if (!bit_v) shift_next = shift_reg + 12'h100;
                            step_next = DS_C0;
                        end
                        DS_C0, DS_C1, DS_C2, DS_C3:
                        begin
                            if (bit_v)
                            begin
                                clen_next  = 9'(step_reg - DS_C0) + 9'd3;
                                state_next = FS_CSET;
                            end
                            else step_next = step_reg + 5'd1;
                        end
                        DS_C4: step_next = bit_v ? DS_C5 : DS_C6;
                        DS_C5:
                        begin
                            clen_next  = bit_v ? 9'd8 : 9'd7;
                            state_next = FS_CSET;
                        end
                        DS_C6:
                        begin
                            if (bit_v) step_next = DS_LENB;
                            else
                            begin
                                mlen_next = 9'd9;
                                step_next = DS_C7;
                            end
                        end
                        DS_C7:
                        begin
                            if (bit_v) mlen_next = 9'd13;
                            step_next = DS_C8;
                        end
                        DS_C8:
                        begin
                            if (bit_v) mlen_next = mlen_reg + 9'd2;
                            step_next = DS_C9;
                        end
                        DS_C9:
                        begin
                            mlen_next  = mlen_reg + 9'(bit_v);
                            clen_next  = mlen_reg + 9'(bit_v);
                            state_next = FS_CSET;
                        end
                        DS_S1:
                        begin
                            if (bit_v)
                            begin
                                dist_next = dist_reg + 14'h100;
                                step_next = DS_S2;
                            end
                            else if (dist_reg == 14'd1) step_next = DS_S5;
                            else
                            begin
                                clen_next  = 9'd2;
                                state_next = FS_CSET;
                            end
                        end
                        DS_S2:
                        begin
                            if (!bit_v) dist_next = dist_reg + 14'h400;
                            step_next = DS_S3;
                        end
                        DS_S3:
                        begin
                            if (!bit_v) dist_next = dist_reg + 14'h200;
                            step_next = DS_S4;
                        end
                        DS_S4:
                        begin
                            if (!bit_v) dist_next = dist_reg + 14'h100;
                            clen_next  = 9'd2;
                            state_next = FS_CSET;
                        end
                        DS_S5:
                        begin
                            if (!bit_v) fin_next = 1'b1;
                            step_next = DS_TOKEN;
                        end
                        default: step_next = DS_TOKEN;
                    endcase
                end
            end

            FS_CSET:
            begin
                // Check the distance, clip the length and predict the end state.
                step_next  = DS_TOKEN;
                cdist_next = d_sum;
                if (SIZE_BITS'(d_sum) > produced_reg)
                begin
                    fault_next = STAT_DIST;
                    state_next = FS_RUN;
                end
                else
                begin
                    if (SIZE_BITS'(clen_reg) > room) clen_next = room[8:0];
                    mdone_next = (SIZE_BITS'(clen_reg) >= room);
                    mstat_next = (last_reg && (flag_reg == 17'd1
                                  || SIZE_BITS'(clen_reg) < room)) ? STAT_SHORT : STAT_OK;
                    state_next = (room == '0) ? FS_RUN : FS_CRD;
                end
            end

            FS_CRD:
            begin
                // A full word goes out before the next copied byte.
                if (fill_reg == 4'(LANE_BYTES))
                begin
                    if (out_free)
                    begin
                        out_v_next = 1'b1;
                        out_w_next = '{out_bytes: lane_reg, byte_count: fill_reg,
                                       run_end: 1'b0, stream_done: mdone_reg,
                                       status: mstat_reg};
                        lane_next  = '0;
                        fill_next  = '0;
                        state_next = FS_CWR;
                    end
                end
                else
                begin
                    state_next = FS_CWR;
                end
            end

            FS_CWR:
            begin
                ram_we        = 1'b1;
                ram_wdata     = ram_rdata;
                lane_next[8*fill_reg[2:0] +: 8] = ram_rdata;
                fill_next     = fill_reg + 4'd1;
                produced_next = produced_reg + SIZE_BITS'(1);
                clen_next     = clen_reg - 9'd1;
                state_next    = (clen_reg == 9'd1) ? FS_RUN : FS_CRD;
            end

            FS_FLUSH:
            begin
                if (out_free)
                begin
                    out_v_next = 1'b1;
                    out_w_next = '{out_bytes: lane_reg, byte_count: fill_reg, run_end: 1'b1,
                                   stream_done: fin_reg, status: fin_stat};
                    lane_next  = '0;
                    fill_next  = '0;
                    state_next = FS_IDLE;
                    if (last_reg)
                    begin
                        // End of file: the next byte starts a new stream.
                        produced_next = '0;
                        target_next   = '0;
                        hdr_next      = '0;
                        flag_next     = 17'd2;
                        wlow_next     = '0;
                        whalf_next    = 1'b0;
                        step_next     = DS_TOKEN;
                        dist_next     = '0;
                        shift_next    = '0;
                        mlen_next     = '0;
                        fin_next      = 1'b0;
                        fault_next    = STAT_OK;
                        last_next     = 1'b0;
                    end
                end
            end

            default: state_next = FS_IDLE;
        endcase
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        clen_reg  <= clen_next;
        cdist_reg <= cdist_next;
        mdone_reg <= mdone_next;
        mstat_reg <= mstat_next;
        out_w_reg <= out_w_next;
    end

    // Control and stream state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FS_IDLE;
            produced_reg <= '0;
            target_reg   <= '0;
            hdr_reg      <= '0;
            flag_reg     <= 17'd2;
            wlow_reg     <= '0;
            whalf_reg    <= 1'b0;
            step_reg     <= DS_TOKEN;
            dist_reg     <= '0;
            shift_reg    <= '0;
            mlen_reg     <= '0;
            fin_reg      <= 1'b0;
            fault_reg    <= STAT_OK;
            last_reg     <= 1'b0;
            lane_reg     <= '0;
            fill_reg     <= '0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            produced_reg <= produced_next;
            target_reg   <= target_next;
            hdr_reg      <= hdr_next;
            flag_reg     <= flag_next;
            wlow_reg     <= wlow_next;
            whalf_reg    <= whalf_next;
            step_reg     <= step_next;
            dist_reg     <= dist_next;
            shift_reg    <= shift_next;
            mlen_reg     <= mlen_next;
            fin_reg      <= fin_next;
            fault_reg    <= fault_next;
            last_reg     <= last_next;
            lane_reg     <= lane_next;
            fill_reg     <= fill_next;
            out_v_reg    <= out_v_next;
        end
    end

    assign out_ch.valid       = out_v_reg;
    assign out_ch.out_bytes   = out_w_reg.out_bytes;
    assign out_ch.byte_count  = out_w_reg.byte_count;
    assign out_ch.run_end     = out_w_reg.run_end;
    assign out_ch.stream_done = out_w_reg.stream_done;
    assign out_ch.status      = out_w_reg.status;
endmodule

[hdl/lz_bitflag_decompressor_core.sv]
// A header byte other than the last gives its word through the flush state; a literal
// passes the run state, which takes further flag bits until the next byte is needed.
// The run state takes one flag bit per cycle; a match copy passes a set-up state, then
// a read state and a write state for each copied byte through the history RAM.
// A four-word input queue lets bytes arrive while a copy runs.
// Reset: rst_n clears all control and stream state at once; the history RAM is not
// cleared, as a match only reads bytes written earlier in the same file.
// ---------------------------------------------------------------------------
// lz_bitflag_decompressor_core: bit-flag LZ77 decompressor
// Input queue at the front, decoding engine with 8 KiB history at the back.
// ---------------------------------------------------------------------------
module lz_bitflag_decompressor_core (
    input  logic        clk,
    input  logic        rst_n,
    lzbf_in_if.sink     in_ch,
    lzbf_out_if.source  out_ch
);
    import lzbf_pkg::*;

    in_word_t q_word;
    logic     q_valid;
    logic     q_ready;

    // Input queue.
    lzbf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_word  (q_word),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    // Decoder and copy engine.
    lzbf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_word  (q_word),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .out_ch  (out_ch)
    );
endmodule

[hdl/lzbf_checker.sv]
// ---------------------------------------------------------------------------
// lzbf_checker: port checks of the decompressor
// Watches the output channel of the top level over time.
// ---------------------------------------------------------------------------
module lzbf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] byte_count,
    input logic       run_end,
    input logic       stream_done,
    input logic [1:0] status
);
    import lzbf_pkg::*;

    // A stalled word stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // A word never holds more bytes than a lane group.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count <= 4'(LANE_BYTES))
        else $error("byte count above lane width");

    // Only the closing word of an input byte may be partly filled or empty.
    a_partial: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count != 4'(LANE_BYTES) |-> run_end)
        else $error("partial word not marked as closing word");

    // A bad distance produces nothing and never reports a finished stream.
    a_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_DIST |-> !stream_done && byte_count == 4'd0)
        else $error("distance fault with data or done flag");
endmodule

bind lz_bitflag_decompressor_core lzbf_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .byte_count  (out_ch.byte_count),
    .run_end     (out_ch.run_end),
    .stream_done (out_ch.stream_done),
    .status      (out_ch.status)
);

[bench/tb_lz_bitflag_decompressor_core.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_lz_bitflag_decompressor_core: self-checking bench of the LZ77 decompressor
// Streams compressed files into the core. Most files are well formed: their
// headers, flag words and offsets are chosen from the predicted
// decoder state. Some files are cut short or carry trailing noise. Every
// output word is checked against a bit-exact prediction of the decoder.
// ---------------------------------------------------------------------------

// Holds the predicted output words and checks those that arrive.
class lzbf_word_board;
    lzbf_pkg::out_word_t pending_q[$];
    int        mismatches;
    int        checked;

    function new();
        mismatches = 0;
        checked    = 0;
    endfunction

    function void note(lzbf_pkg::out_word_t w);
        pending_q.push_back(w);
    endfunction

    function int waiting();
        return pending_q.size();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task check(lzbf_pkg::out_word_t got);
        lzbf_pkg::out_word_t want;
        checked++;
        if (pending_q.size() == 0)
        begin
            report("unexpected word", got.out_bytes, 64'd0);
            return;
        end
        want = pending_q.pop_front();
        if (got.out_bytes !== want.out_bytes)
            report("out_bytes", got.out_bytes, want.out_bytes);
        if (got.byte_count !== want.byte_count)
            report("byte_count", got.byte_count, want.byte_count);
        if (got.run_end !== want.run_end)
            report("run_end", got.run_end, want.run_end);
        if (got.stream_done !== want.stream_done)
            report("stream_done", got.stream_done, want.stream_done);
        if (got.status !== want.status)
            report("status", got.status, want.status);
    endtask
endclass

module tb_lz_bitflag_decompressor_core;
    import lzbf_pkg::*;

    logic clk;
    logic rst_n;

    lzbf_in_if  in_ch ();
    lzbf_out_if out_ch ();

    lz_bitflag_decompressor_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    lzbf_word_board board;

    // Predicted decoder state.
    logic [7:0]  hist [0:WIN_BYTES-1];
    int unsigned produced;
    int unsigned target_size;
    int unsigned hdr_idx;
    int unsigned flags;
    int unsigned low_half;
    bit          half_seen;
    logic [4:0]  dstep;
    int unsigned match_dist;
    int unsigned shift_acc;
    int unsigned copy_len;
    bit          finished;
    logic [1:0]  fault;

    // Words built while one input word is decoded.
    out_word_t   group_q[$];
    logic [63:0] lane_acc;
    int unsigned lane_fill;

    int idle_pct;
    int stall_pct;
    int bytes_sent;
    int files_sent;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function void clear_stream();
        produced    = 0;
        target_size = 0;
        hdr_idx     = 0;
        flags       = 2;
        low_half    = 0;
        half_seen   = 1'b0;
        dstep       = DS_TOKEN;
        match_dist  = 0;
        shift_acc   = 0;
        copy_len    = 0;
        finished    = 1'b0;
        fault       = STAT_OK;
    endfunction

    function void close_group();
        out_word_t w;
        w             = '0;
        w.out_bytes   = lane_acc;
        w.byte_count  = lane_fill[3:0];
        group_q.push_back(w);
        lane_acc  = '0;
        lane_fill = 0;
    endfunction

    function void put_byte(logic [7:0] b);
        hist[produced % WIN_BYTES] = b;
        produced  = (produced + 1) & ((1 << SIZE_BITS) - 1);
        lane_acc  = lane_acc | (64'(b) << (8 * lane_fill));
        lane_fill = lane_fill + 1;
        if (lane_fill >= LANE_BYTES)
            close_group();
    endfunction

    function void copy_back(int unsigned len);
        int unsigned d;
        int unsigned room;
        d     = match_dist + shift_acc;
        room  = target_size - produced;
        dstep = DS_TOKEN;
        if (d > produced)
        begin
            fault = STAT_DIST;
            return;
        end
        if (len > room)
            len = room;
        for (int unsigned i = 0; i < len; i++)
            put_byte(hist[(produced - d) % WIN_BYTES]);
    endfunction

    function bit wants_byte(logic [4:0] s);
        return s == DS_LIT || s == DS_LOFS || s == DS_SOFS || s == DS_LENB;
    endfunction

    // One flag bit through the token parser.
    function void take_flag(bit f);
        case (dstep)
            DS_TOKEN: dstep = f ? DS_LIT : DS_KIND;
            DS_KIND:  dstep = f ? DS_LOFS : DS_SOFS;
            DS_L1:
            begin
                if (!f) shift_acc += 'h100;
                dstep = DS_L2;
            end
            DS_L2:
                if (!f) begin match_dist += 'h200; dstep = DS_L3; end
                else dstep = DS_C0;
            DS_L3:
                if (!f) begin shift_acc <<= 1; dstep = DS_L4; end
                else dstep = DS_C0;
            DS_L4:
            begin
                if (!f) shift_acc += 'h100;
                match_dist += 'h200;
                dstep = DS_L5;
            end
            DS_L5:
                if (!f) begin shift_acc <<= 1; dstep = DS_L6; end
                else dstep = DS_C0;
            DS_L6:
            begin
                if (!f) shift_acc += 'h100;
                match_dist += 'h400;
                dstep = DS_L7;
            end
            DS_L7:
                if (!f) begin match_dist += 'h800; shift_acc <<= 1; dstep = DS_L8; end
                else dstep = DS_C0;
            DS_L8:
            begin
                if (!f) shift_acc += 'h100;
                dstep = DS_C0;
            end
            DS_C0: if (f) copy_back(3); else dstep = DS_C1;
            DS_C1: if (f) copy_back(4); else dstep = DS_C2;
            DS_C2: if (f) copy_back(5); else dstep = DS_C3;
            DS_C3: if (f) copy_back(6); else dstep = DS_C4;
            DS_C4: dstep = f ? DS_C5 : DS_C6;
            DS_C5: copy_back(f ? 8 : 7);
            DS_C6:
                if (f) dstep = DS_LENB;
                else begin copy_len = 9; dstep = DS_C7; end
            DS_C7:
            begin
                if (f) copy_len = 13;
                dstep = DS_C8;
            end
            DS_C8:
            begin
                if (f) copy_len += 2;
                dstep = DS_C9;
            end
            DS_C9:
            begin
                if (f) copy_len += 1;
                copy_back(copy_len);
            end
            DS_S1:
                if (f) begin match_dist += 'h100; dstep = DS_S2; end
                else if (match_dist == 1) dstep = DS_S5;
                else copy_back(2);
            DS_S2:
            begin
                if (!f) match_dist += 'h400;
                dstep = DS_S3;
            end
            DS_S3:
            begin
                if (!f) match_dist += 'h200;
                dstep = DS_S4;
            end
            DS_S4:
            begin
                if (!f) match_dist += 'h100;
                copy_back(2);
            end
            DS_S5:
            begin
                if (!f) finished = 1'b1;
                dstep = DS_TOKEN;
            end
            default: dstep = DS_TOKEN;
        endcase
    endfunction

    // Works out the output words of one accepted input word.
    function void predict_words(logic [7:0] b, bit last);
        logic [1:0] st;
        group_q.delete();
        lane_acc  = '0;
        lane_fill = 0;

        if (hdr_idx < HDR_LEN)
        begin
            if (hdr_idx == 10) target_size |= int'(b >> 2) << 16;
            else if (hdr_idx == 11) target_size |= b;
            else if (hdr_idx == 12) target_size |= int'(b) << 8;
            hdr_idx++;
            if (hdr_idx == HDR_LEN)
                flags >>= 1;
        end
        else if (flags == 1)
        begin
            if (!half_seen) begin low_half = b; half_seen = 1'b1; end
            else begin flags = 'h10000 | (int'(b) << 8) | low_half; half_seen = 1'b0; end
        end
        else if (!finished && fault == STAT_OK && wants_byte(dstep))
        begin
            case (dstep)
                DS_LIT: begin put_byte(b); dstep = DS_TOKEN; end
                DS_LOFS: begin match_dist = 'h100 - b; shift_acc = 0; dstep = DS_L1; end
                DS_SOFS: begin match_dist = 'h100 - b; shift_acc = 0; dstep = DS_S1; end
                default: begin copy_len = b + 17; copy_back(copy_len); end
            endcase
        end

        // Consume flag bits until a byte is needed or the stream stops.
        if (hdr_idx >= HDR_LEN)
        begin
            while (!finished && fault == STAT_OK)
            begin
                if (dstep == DS_TOKEN && produced >= target_size)
                begin
                    finished = 1'b1;
                    break;
                end
                if (wants_byte(dstep) || flags <= 1)
                    break;
                take_flag(flags[0]);
                flags >>= 1;
            end
        end

        if (lane_fill > 0 || group_q.size() == 0)
            close_group();

        st = fault;
        if (last && st == STAT_OK && (hdr_idx < HDR_LEN || flags == 1 || !finished))
            st = STAT_SHORT;
        foreach (group_q[k])
        begin
            group_q[k].run_end     = (k == group_q.size() - 1);
            group_q[k].stream_done = finished;
            group_q[k].status      = st;
            board.note(group_q[k]);
        end
        if (last)
            clear_stream();
    endfunction

    // Offers one word and waits for it to be taken.
    task automatic offer_byte(logic [7:0] b, bit last);
        if ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.final_byte <= last;
        do @(posedge clk); while (!in_ch.ready);
        predict_words(b, last);
        bytes_sent++;
    endtask

    // Holds the input until every predicted word has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.waiting() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function logic [7:0] flag_byte(int lit_pct);
        logic [7:0] f;
        for (int i = 0; i < 8; i++)
            f[i] = ($urandom_range(99) < lit_pct);
        return f;
    endfunction

    // Sends one file whose bytes follow the predicted parser state. It is cut
    // at max_len bytes; once decoding stops, tail noise words precede the end.
    task automatic send_file(int unsigned tsize, int lit_pct, int max_len, int tail);
        logic [7:0] b;
        int         n;
        int         span;
        bit         stop;
        n = 0;
        forever
        begin
            stop = (hdr_idx >= HDR_LEN) && flags != 1 && (finished || fault != STAT_OK);
            if (stop && tail == 0)
                break;
            if (n == max_len - 1)
                break;
            if (stop)
                tail--;
            b = 8'($urandom_range(255));
            if (hdr_idx < HDR_LEN)
            begin
                if (hdr_idx == 10) b = {tsize[21:16], b[1:0]};
                else if (hdr_idx == 11) b = tsize[7:0];
                else if (hdr_idx == 12) b = tsize[15:8];
            end
            else if (flags == 1)
                b = flag_byte(lit_pct);
            else if (!stop && (dstep == DS_LOFS || dstep == DS_SOFS))
            begin
                span = (produced < 256) ? ((produced < 1) ? 1 : produced) : 256;
                case ($urandom_range(9))
                    0: b = 8'($urandom_range(255));
                    1, 2: b = 8'hFF;
                    default: b = 8'(256 - $urandom_range(1, span));
                endcase
            end
            offer_byte(b, 1'b0);
            n++;
        end
        offer_byte(8'($urandom_range(255)), 1'b1);
        files_sent++;
    endtask

    // Output side: check taken words, then choose the next ready.
    initial
    begin
        out_word_t got;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.out_bytes   = out_ch.out_bytes;
                got.byte_count  = out_ch.byte_count;
                got.run_end     = out_ch.run_end;
                got.stream_done = out_ch.stream_done;
                got.status      = out_ch.status;
                board.check(got);
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Main sequence.
    initial
    begin
        int unsigned tsize;
        int          lit;
        board      = new();
        idle_pct   = 0;
        stall_pct  = 0;
        bytes_sent = 0;
        files_sent = 0;
        clear_stream();
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'h00;
        in_ch.final_byte = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: zero output size, then a header cut short, then a
        // two-byte file, also cut short in its header.
        send_file(0, 90, 40, 0);
        send_file(0, 90, 5, 0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h00, 1'b1);
        files_sent++;
        wait_drained();

        // Random files in four idling phases.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            while (bytes_sent < 80 * (ph + 1))
            begin
                case ($urandom_range(9))
                    0: tsize = $urandom_range(200, 400);
                    1: tsize = 22'h3FFFFF - $urandom_range(3);
                    default: tsize = $urandom_range(1, 64);
                endcase
                lit = (tsize > 100) ? 40 : $urandom_range(50, 85);
                if ($urandom_range(7) == 0)
                    send_file(tsize, lit, $urandom_range(2, 30), 0);
                else
                    send_file(tsize, lit, 90, ($urandom_range(3) == 0) ? 3 : 0);
            end
            wait_drained();
        end

        $display("Ran %0d files of %0d compressed words through four idling phases;",
                 files_sent, bytes_sent);
        $display("%0d output words checked, covering literals, matches, end codes and faults.",
                 board.checked);
        if (board.mismatches == 0 && board.waiting() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
